// File: design/tbb_pkg.sv
package tbb_pkg;

   localparam int FRAC_BITS = 16;

   localparam int Q_W   = 32;
   localparam int PROD_W = 2 * Q_W;
   localparam int SH_W  = PROD_W - FRAC_BITS;
   localparam int SUM_W = SH_W + 2;
   localparam int SIZE_W = 31;

   typedef logic signed [Q_W-1:0]    q_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SH_W-1:0]   sh_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic        [SIZE_W-1:0] size_type;

   localparam q_type Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam q_type Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

   localparam size_type SIZE_RESET = SIZE_W'(1 << FRAC_BITS);

   typedef enum logic [2:0] {
      REG_OFFSET_X = 3'd0,
      REG_OFFSET_Y = 3'd1,
      REG_OFFSET_Z = 3'd2,
      REG_SIZE_X   = 3'd3,
      REG_SIZE_Y   = 3'd4,
      REG_SIZE_Z   = 3'd5
   } reg_index_type;

   // low and high face coordinate of the box along one axis
   typedef struct packed {
      q_type lo;
      q_type hi;
   } corner_type;

   // clamp to the 32-bit signed range
   function automatic q_type sat_q(input sum_type v);
      if (v > sum_type'(Q_MAX)) begin
         return Q_MAX;
      end else if (v < sum_type'(Q_MIN)) begin
         return Q_MIN;
      end else begin
         return v[Q_W-1:0];
      end
   endfunction

endpackage

// File: design/tbb_csr.sv
module tbb_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_wdata,
   output tbb_pkg::corner_type [2:0] corners
);
   import tbb_pkg::*;

   q_type    offset_ff [3];
   size_type size_ff   [3];
   logic     ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            offset_ff[a] <= '0;
            size_ff[a]   <= SIZE_RESET;
         end
      end else begin
         ready_ff <= 1'b1;
         if (csr_valid && ready_ff) begin
            unique case (csr_index)
               REG_OFFSET_X: offset_ff[0] <= csr_wdata;
               REG_OFFSET_Y: offset_ff[1] <= csr_wdata;
               REG_OFFSET_Z: offset_ff[2] <= csr_wdata;
               REG_SIZE_X:   size_ff[0]   <= csr_wdata[SIZE_W-1:0];
               REG_SIZE_Y:   size_ff[1]   <= csr_wdata[SIZE_W-1:0];
               REG_SIZE_Z:   size_ff[2]   <= csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign csr_ready = ready_ff;

   // faces at offset -/+ half side, half side truncated
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         corners[a].lo = sat_q(sum_type'(offset_ff[a])
                               - sum_type'({1'b0, size_ff[a][SIZE_W-1:1]}));
         corners[a].hi = sat_q(sum_type'(offset_ff[a])
                               + sum_type'({1'b0, size_ff[a][SIZE_W-1:1]}));
      end
   end

endmodule

// File: design/tbb_mul.sv
module tbb_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           valid_in,
   input  tbb_pkg::q_type [2:0][3:0]      m_in,
   input  tbb_pkg::corner_type [2:0]      corners_in,
   output logic                           valid_out,
   output tbb_pkg::prod_type [2:0][2:0]   prod_lo,
   output tbb_pkg::prod_type [2:0][2:0]   prod_hi,
   output tbb_pkg::q_type [2:0]           trans
);
   import tbb_pkg::*;

   logic valid_ff;
   prod_type [2:0][2:0] prod_lo_ff;
   prod_type [2:0][2:0] prod_hi_ff;
   q_type [2:0] trans_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // one product per matrix entry and face
   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            prod_lo_ff[r][k] <= $signed(m_in[r][k]) * $signed(corners_in[k].lo);
            prod_hi_ff[r][k] <= $signed(m_in[r][k]) * $signed(corners_in[k].hi);
         end
         trans_ff[r] <= m_in[r][3];
      end
   end

   assign valid_out = valid_ff;
   assign prod_lo   = prod_lo_ff;
   assign prod_hi   = prod_hi_ff;
   assign trans     = trans_ff;

endmodule

// File: design/tbb_reduce.sv
module tbb_reduce (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_in,
   input  tbb_pkg::prod_type [2:0][2:0]  prod_lo,
   input  tbb_pkg::prod_type [2:0][2:0]  prod_hi,
   input  tbb_pkg::q_type [2:0]          trans,
   output logic                          valid_out,
   output tbb_pkg::q_type [2:0]          bound_min,
   output tbb_pkg::q_type [2:0]          bound_max
);
   import tbb_pkg::*;

   logic s3_valid_ff, s4_valid_ff, s5_valid_ff;
   sh_type  [2:0][2:0] s3_min_ff, s3_max_ff;
   q_type   [2:0]      s3_trans_ff;
   sum_type [2:0]      s4_min_a_ff, s4_min_b_ff, s4_max_a_ff, s4_max_b_ff;
   q_type   [2:0]      min_ff, max_ff;
   prod_type [2:0][2:0] pick_lo, pick_hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= valid_in;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // Each term depends on one face choice, so the corner extremes are
   // the sums of per-term extremes. Floor scaling keeps the order.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            if (prod_lo[r][k] < prod_hi[r][k]) begin
               pick_lo[r][k] = prod_lo[r][k];
               pick_hi[r][k] = prod_hi[r][k];
            end else begin
               pick_lo[r][k] = prod_hi[r][k];
               pick_hi[r][k] = prod_lo[r][k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            s3_min_ff[r][k] <= pick_lo[r][k][PROD_W-1:FRAC_BITS];
            s3_max_ff[r][k] <= pick_hi[r][k][PROD_W-1:FRAC_BITS];
         end
         s3_trans_ff[r] <= trans[r];
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         s4_min_a_ff[r] <= sum_type'(s3_min_ff[r][0]) + sum_type'(s3_min_ff[r][1]);
         s4_min_b_ff[r] <= sum_type'(s3_min_ff[r][2]) + sum_type'(s3_trans_ff[r]);
         s4_max_a_ff[r] <= sum_type'(s3_max_ff[r][0]) + sum_type'(s3_max_ff[r][1]);
         s4_max_b_ff[r] <= sum_type'(s3_max_ff[r][2]) + sum_type'(s3_trans_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         min_ff[r] <= sat_q(s4_min_a_ff[r] + s4_min_b_ff[r]);
         max_ff[r] <= sat_q(s4_max_a_ff[r] + s4_max_b_ff[r]);
      end
   end

   assign valid_out = s5_valid_ff;
   assign bound_min = min_ff;
   assign bound_max = max_ff;

`ifndef SYNTHESIS
   a_valid_delay: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff |-> $past(valid_in, 3))
      else $error("result strobe without an item three stages back");
   a_order: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff |-> (min_ff[0] <= max_ff[0]) && (min_ff[1] <= max_ff[1])
                      && (min_ff[2] <= max_ff[2]))
      else $error("lower bound above upper bound");
`endif

endmodule

// File: design/transformed_box_bounds_top.sv
// Transformed box bounds: axis-aligned bounds of a configured box after an
// affine transform.
//
// Configuration channel: csr_valid/csr_ready with csr_index and csr_wdata.
// Indexes 0..2 set the center offset x/y/z, 3..5 the side lengths x/y/z.
// Other indexes are ignored. Write only while no item is in flight.
// Request channel: an item transfers on a rising edge with start high and
// busy low. busy is a register set by reset and cleared on an edge with
// reset low; while busy is low, one matrix per cycle.
// Response channel: rsp_valid strobes for one cycle with the six bounds; the
// receiver cannot stall, so the response has no backpressure.
// Pipeline stage registers, in order: input, products, min/max, partial
// sums, saturated sums; the result strobes from the last of them.
// Throughput: one item per cycle while busy is low, set by the fully pipelined 18 multipliers.
// Reset (synchronous): offsets return to 0, sizes to 1.0, the pipeline
// drains its valid bits and no result strobes until new items arrive.
module transformed_box_bounds_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tbb_pkg::q_type        req_m_r0c0,
   input  tbb_pkg::q_type        req_m_r0c1,
   input  tbb_pkg::q_type        req_m_r0c2,
   input  tbb_pkg::q_type        req_m_r0c3,
   input  tbb_pkg::q_type        req_m_r1c0,
   input  tbb_pkg::q_type        req_m_r1c1,
   input  tbb_pkg::q_type        req_m_r1c2,
   input  tbb_pkg::q_type        req_m_r1c3,
   input  tbb_pkg::q_type        req_m_r2c0,
   input  tbb_pkg::q_type        req_m_r2c1,
   input  tbb_pkg::q_type        req_m_r2c2,
   input  tbb_pkg::q_type        req_m_r2c3,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   output logic                  rsp_valid,
   output tbb_pkg::q_type        rsp_min_x,
   output tbb_pkg::q_type        rsp_max_x,
   output tbb_pkg::q_type        rsp_min_y,
   output tbb_pkg::q_type        rsp_max_y,
   output tbb_pkg::q_type        rsp_min_z,
   output tbb_pkg::q_type        rsp_max_z
);
   import tbb_pkg::*;

   logic busy_ff;
   logic req_accept;

   corner_type [2:0]    corners;
   logic                s1_valid_ff;
   q_type [2:0][3:0]    s1_m_ff;
   corner_type [2:0]    s1_corners_ff;

   logic                mul_valid;
   prod_type [2:0][2:0] prod_lo, prod_hi;
   q_type [2:0]         trans;

   logic                red_valid;
   q_type [2:0]         bound_min, bound_max;

   // hold off requests in reset; busy clears on an edge with reset low
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy       = busy_ff;
   assign req_accept = start && !busy_ff;

   tbb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .corners   (corners)
   );

   // input stage: capture the matrix together with the box faces
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_m_ff[0] <= {req_m_r0c3, req_m_r0c2, req_m_r0c1, req_m_r0c0};
      s1_m_ff[1] <= {req_m_r1c3, req_m_r1c2, req_m_r1c1, req_m_r1c0};
      s1_m_ff[2] <= {req_m_r2c3, req_m_r2c2, req_m_r2c1, req_m_r2c0};
      s1_corners_ff <= corners;
   end

   tbb_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (s1_valid_ff),
      .m_in       (s1_m_ff),
      .corners_in (s1_corners_ff),
      .valid_out  (mul_valid),
      .prod_lo    (prod_lo),
      .prod_hi    (prod_hi),
      .trans      (trans)
   );

   tbb_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (mul_valid),
      .prod_lo   (prod_lo),
      .prod_hi   (prod_hi),
      .trans     (trans),
      .valid_out (red_valid),
      .bound_min (bound_min),
      .bound_max (bound_max)
   );

   // drive the response straight from the final stage registers
   assign rsp_valid = red_valid;
   assign rsp_min_x = bound_min[0];
   assign rsp_max_x = bound_max[0];
   assign rsp_min_y = bound_min[1];
   assign rsp_max_y = bound_max[1];
   assign rsp_min_z = bound_min[2];
   assign rsp_max_z = bound_max[2];

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, 5))
      else $error("response without a request transfer five edges earlier");
`endif

endmodule
